// ----- design/mecanum_wheel_mixer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Mecanum wheel mixer assertion macros
// Shared property shapes for the checker; clk and rst come from the user.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIXER_CORE_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MWM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Constants, command and wheel types, and the wheel saturation function.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // Mixing limits in percent
  localparam int SUM_LIMIT  = 80;
  localparam int ROT_FLOOR  = 20;
  localparam int FULL_SCALE = 100;

  // Stream widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 72;

  // Command queue default depth
  localparam int QUEUE_DEPTH = 4;

  // Divider: one quotient bit per stage, quotient never exceeds 80
  localparam int DIV_STAGES = 7;
  localparam int REM_W      = 14;

  // Divide by 100 as multiply by ceil(2^30/100) and shift
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_MUL   = 24'd10737419;

  // Direction codes
  localparam logic [1:0] DIR_STOP   = 2'd0;
  localparam logic [1:0] DIR_FWD    = 2'd1;
  localparam logic [1:0] DIR_REV    = 2'd2;
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  // Register map: index taken from paddr[2]
  localparam int         ADDR_W       = 3;
  localparam logic       REG_ENABLE   = 1'b0;
  localparam logic       REG_PERIOD   = 1'b1;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] w;
    logic [8:0]        sum;
    logic              rescale;
    logic [REM_W-1:0]  dividend;
  } cmd_t;

  // One wheel after saturation
  typedef struct packed {
    logic [1:0] dir;
    logic [6:0] mag;
  } wheel_t;

  // Saturate a mixed wheel value to +-100 and split into direction and size
  function automatic wheel_t wheel_drive(input logic signed [9:0] v);
    wheel_t            r;
    logic signed [9:0] neg;
    neg = -v;
    if (v > 10'sd100) begin
      r.dir = DIR_FWD;
      r.mag = 7'd100;
    end else if (v < -10'sd100) begin
      r.dir = DIR_REV;
      r.mag = 7'd100;
    end else if (v > 10'sd0) begin
      r.dir = DIR_FWD;
      r.mag = v[6:0];
    end else if (v < 10'sd0) begin
      r.dir = DIR_REV;
      r.mag = neg[6:0];
    end else begin
      r.dir = DIR_STOP;
      r.mag = 7'd0;
    end
    return r;
  endfunction

endpackage

// ----- design/mwm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer front end
// Unpacks a command beat, forms |x|+|y|, the rescale flag and the dividend.
// ----------------------------------------------------------------------------
module mwm_front (
  input  logic [mwm_pkg::IN_W-1:0] in_data,
  output mwm_pkg::cmd_t            cmd
);
  import mwm_pkg::*;

  logic signed [7:0] x;
  logic signed [7:0] y;
  logic signed [7:0] w;
  logic [7:0]        x_mag;
  logic [7:0]        y_mag;
  logic [8:0]        sum;

  // Split the beat into its fields
  assign x = in_data[7:0];
  assign y = in_data[15:8];
  assign w = in_data[23:16];

  // Magnitudes; -128 wraps to 8'h80, which reads as 128 unsigned
  assign x_mag = x[7] ? 8'(-x) : 8'(x);
  assign y_mag = y[7] ? 8'(-y) : 8'(y);
  assign sum   = {1'b0, x_mag} + {1'b0, y_mag};

  // Classify and build |x|*80 with two shifts
  always_comb begin
    cmd.x        = x;
    cmd.y        = y;
    cmd.w        = w;
    cmd.sum      = sum;
    cmd.rescale  = sum > 9'(SUM_LIMIT);
    cmd.dividend = (REM_W'(x_mag) << 6) + (REM_W'(x_mag) << 4);
  end

endmodule

// ----- design/mwm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer command queue
// Short FIFO that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module mwm_queue #(
  parameter int DEPTH = mwm_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mwm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mwm_pkg::cmd_t pop_data,
  output logic          empty
);
  import mwm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Store a beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

endmodule

// ----- design/mwm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer back end
// Pipelined rescale divider, mixing, saturation and PWM width scaling.
// ----------------------------------------------------------------------------
module mwm_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      drive_enable,
  input  logic [15:0]               period_count,
  input  logic                      q_valid,
  input  mwm_pkg::cmd_t             q_data,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [mwm_pkg::OUT_W-1:0] m_tdata
);
  import mwm_pkg::*;

  typedef struct packed {
    cmd_t                  cmd;
    logic [REM_W-1:0]      rem;
    logic [DIV_STAGES-1:0] quo;
  } div_t;

  logic              adv;
  div_t              div_r [0:DIV_STAGES];
  logic [DIV_STAGES:0] div_v;

  cmd_t              c;
  logic signed [9:0] qs;
  logic signed [9:0] hs;
  logic signed [9:0] xv;
  logic signed [9:0] yv;
  logic signed [9:0] wv;
  logic [7:0]        w_mag;
  logic [6:0]        head;
  logic              clip;
  wheel_t            wh [0:3];

  logic              mix_v;
  wheel_t            mix_wh [0:3];
  logic              mul_v;
  logic [1:0]        mul_dir [0:3];
  logic [22:0]       mul_prod [0:3];
  logic              out_v;
  logic [1:0]        out_dir [0:3];
  logic [15:0]       out_width [0:3];

  // Whole pipeline moves unless the output beat is stalled
  assign adv   = !out_v || m_tready;
  assign q_pop = adv && q_valid;

  // Load the divider entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0].cmd <= q_data;
      div_r[0].rem <= q_data.dividend;
      div_r[0].quo <= '0;
    end
  end

  // Valid bits through the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_v <= '0;
    end else if (adv) begin
      div_v <= {div_v[DIV_STAGES-1:0], q_valid};
    end
  end

  // Restoring division, one quotient bit per stage, high bit first
  genvar k;
  for (k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam int B = DIV_STAGES - k;
    logic [REM_W:0] dvs;
    logic           ge;

    assign dvs = {6'b0, div_r[k-1].cmd.sum} << B;
    assign ge  = {1'b0, div_r[k-1].rem} >= dvs;

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k].cmd <= div_r[k-1].cmd;
        if (ge) begin
          div_r[k].rem <= REM_W'({1'b0, div_r[k-1].rem} - dvs);
          div_r[k].quo <= div_r[k-1].quo | (DIV_STAGES'(1) << B);
        end else begin
          div_r[k].rem <= div_r[k-1].rem;
          div_r[k].quo <= div_r[k-1].quo;
        end
      end
    end
  end

  // Rescale, clip rotation to headroom, mix and saturate
  always_comb begin
    c  = div_r[DIV_STAGES].cmd;
    qs = $signed({3'b000, div_r[DIV_STAGES].quo});

    if (c.rescale) begin
      xv = c.x[7] ? -qs : qs;
      yv = c.y[7] ? (qs - 10'sd80) : (10'sd80 - qs);
      head = 7'(ROT_FLOOR);
    end else begin
      xv = {{2{c.x[7]}}, c.x};
      yv = {{2{c.y[7]}}, c.y};
      head = 7'(FULL_SCALE) - c.sum[6:0];
    end

    w_mag = c.w[7] ? 8'(-c.w) : 8'(c.w);
    clip  = (w_mag > 8'(ROT_FLOOR)) && (w_mag > {1'b0, head});
    hs    = $signed({3'b000, head});
    if (clip) begin
      wv = c.w[7] ? -hs : hs;
    end else begin
      wv = {{2{c.w[7]}}, c.w};
    end

    wh[0] = wheel_drive(yv - xv - wv);
    wh[1] = wheel_drive(yv + xv + wv);
    wh[2] = wheel_drive(yv + xv - wv);
    wh[3] = wheel_drive(yv - xv + wv);
  end

  // Register mixed wheels; drop to stop when disabled
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (drive_enable) begin
          mix_wh[i] <= wh[i];
        end else begin
          mix_wh[i].dir <= DIR_STOP;
          mix_wh[i].mag <= '0;
        end
      end
    end
  end

  // Scale by the period
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mul_dir[i]  <= mix_wh[i].dir;
        mul_prod[i] <= 23'(mix_wh[i].mag) * 23'(period_count);
      end
    end
  end

  // Divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        out_dir[i]   <= mul_dir[i];
        out_width[i] <= 16'((47'(mul_prod[i]) * 47'(RECIP_MUL)) >> RECIP_SHIFT);
      end
    end
  end

  // Valid bits through mix, multiply and output
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_v <= 1'b0;
      mul_v <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      mix_v <= div_v[DIV_STAGES];
      mul_v <= mix_v;
      out_v <= mul_v;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_width[3], out_dir[3], out_width[2], out_dir[2],
                     out_width[1], out_dir[1], out_width[0], out_dir[0]};

endmodule

// ----- design/mecanum_wheel_mixer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer core
// Body velocity command in, direction and PWM width for four wheels out.
// ----------------------------------------------------------------------------
// The core takes one command beat per clock while the queue has room and
// returns one wheel beat per command, in order. With an empty queue and a
// ready sink, an accepted command goes from the command queue through the
// divider entry stage, seven divider stages of one quotient bit each, then
// mixing, the period multiply and the reciprocal multiply for divide by 100
// to the output. The divider and both multipliers are fully pipelined, so
// throughput is one beat per cycle while the sink is ready; the queue of
// FIFO_DEPTH commands absorbs output stalls before s_tready drops. Registers
// are drive_enable at byte address 0 and the PWM period count at byte
// address 4; write them only while no command is in flight.
module mecanum_wheel_mixer_core #(
  parameter int FIFO_DEPTH = mwm_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Command stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mwm_pkg::IN_W-1:0]   s_tdata,  // x_speed, y_speed, w_speed
  // Wheel stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // a_dir, a_width, b_dir, b_width, c_dir, c_width, d_dir, d_width
  output logic [mwm_pkg::OUT_W-1:0]  m_tdata
);
  import mwm_pkg::*;

  logic        drive_enable;
  logic [15:0] period_count;
  logic        cfg_wr;
  logic        reg_sel;

  cmd_t        front_cmd;
  cmd_t        q_data;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_enable <= 1'b0;
      period_count <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ENABLE: drive_enable <= pwdata[0];
        REG_PERIOD: period_count <= pwdata[15:0];
        default:    drive_enable <= drive_enable;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_ENABLE: prdata = {31'b0, drive_enable};
      REG_PERIOD: prdata = {16'b0, period_count};
      default:    prdata = '0;
    endcase
  end

  // Accept commands while the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  mwm_front u_front (
    .in_data (s_tdata),
    .cmd     (front_cmd)
  );

  mwm_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  mwm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .drive_enable (drive_enable),
    .period_count (period_count),
    .q_valid      (!q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

// ----- design/mwm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer checker
// Port-level properties of the wheel stream, bound to the core.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mixer_core_defines.svh"

module mwm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [mwm_pkg::OUT_W-1:0] m_tdata
);
  import mwm_pkg::*;

  // Hold a stalled wheel beat
  `MWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "wheel beat changed while stalled")

  // No wheel carries the unused direction code
  `MWM_ASSERT_IMPLY(a_dir_legal, m_tvalid, (m_tdata[1:0] != DIR_UNUSED) && (m_tdata[19:18] != DIR_UNUSED) && (m_tdata[37:36] != DIR_UNUSED) && (m_tdata[55:54] != DIR_UNUSED), "illegal wheel direction code")

  // A stopped wheel has zero width
  `MWM_ASSERT_IMPLY(a_stop_zero, m_tvalid, ((m_tdata[1:0] != DIR_STOP) || (m_tdata[17:2] == 16'd0)) && ((m_tdata[19:18] != DIR_STOP) || (m_tdata[35:20] == 16'd0)) && ((m_tdata[37:36] != DIR_STOP) || (m_tdata[53:38] == 16'd0)) && ((m_tdata[55:54] != DIR_STOP) || (m_tdata[71:56] == 16'd0)), "stopped wheel with nonzero width")

endmodule

bind mecanum_wheel_mixer_core mwm_checker u_mwm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
